@@ hw/rtl/packed_pixel_rect_blitter_macros.svh @@
// Assertion helpers for the blitter.
`ifndef PACKED_PIXEL_RECT_BLITTER_MACROS_SVH
`define PACKED_PIXEL_RECT_BLITTER_MACROS_SVH
`define PPRB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
`define PPRB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

@@ hw/rtl/pprb_pkg.sv @@
package pprb_pkg;
  localparam int StoreWords = 16384;
  localparam int AddrBits = $clog2(StoreWords);
  localparam int WordBits = 32;
  localparam logic [31:0] AllOnes = 32'hffffffff;

  localparam logic [2:0] KIND_WRITE = 3'd0;
  localparam logic [2:0] KIND_READ  = 3'd1;
  localparam logic [2:0] KIND_FILL  = 3'd2;
  localparam logic [2:0] KIND_XOR   = 3'd3;
  localparam logic [2:0] KIND_COPY  = 3'd4;

  localparam logic REG_PIX   = 1'b0;
  localparam logic REG_PITCH = 1'b1;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;      // latch command and compute geometry
    logic check;     // register bound results
    logic rd_src;    // issue a read at the source address
    logic rd_dst;    // issue a read at the destination address
    logic wr;        // write back the merged word
    logic step;      // advance word/row counters
    logic do_single; // perform the plain word write or read
  } pprb_cmd_t;

  typedef struct packed {
    logic is_word;   // write/read kind
    logic is_rect;   // nonempty fill/xor/copy
    logic is_copy;
    logic bad;       // region out of store
    logic last;      // current word is the final one
  } pprb_sts_t;
endpackage

@@ hw/rtl/pprb_ram.sv @@
module pprb_ram #(
  parameter int Width = 32,
  parameter int Depth = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

@@ hw/rtl/pprb_ctrl.sv @@
module pprb_ctrl
  import pprb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  pprb_sts_t sts,
  output pprb_cmd_t cmd
);
  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_GEOM  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_SINGL = 9'b000001000,
    S_RSRC  = 9'b000010000,
    S_RDST  = 9'b000100000,
    S_WAIT  = 9'b001000000,
    S_WRITE = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;
  state_t state, state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: if (in_valid) begin
        cmd.load = 1'b1;
        state_next = S_GEOM;
      end
      S_GEOM: begin
        cmd.check = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.is_word) state_next = S_SINGL;
        else if (sts.is_rect && !sts.bad) state_next = S_RSRC;
        else state_next = S_OUT;
      end
      S_SINGL: begin
        cmd.do_single = 1'b1;
        state_next = S_WAIT;
      end
      S_RSRC: begin
        cmd.rd_src = 1'b1;
        state_next = sts.is_copy ? S_RDST : S_WAIT;
      end
      S_RDST: begin
        cmd.rd_dst = 1'b1;
        state_next = S_WAIT;
      end
      S_WAIT: state_next = sts.is_word ? S_OUT : S_WRITE;
      S_WRITE: begin
        cmd.wr = 1'b1;
        cmd.step = 1'b1;
        state_next = sts.last ? S_OUT : S_RSRC;
      end
      S_OUT: if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

`include "packed_pixel_rect_blitter_macros.svh"
  `PPRB_ASSERT_IMP(a_onehot, 1'b1, $onehot(state))
  `PPRB_ASSERT_NXT(a_accept_geom, in_valid && in_ready, state == S_GEOM)
  `PPRB_ASSERT_IMP(a_no_wr_bad, cmd.wr, !sts.bad && sts.is_rect)
endmodule

@@ hw/rtl/pprb_dp.sv @@
module pprb_dp
  import pprb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  input  logic [2:0]  kind,
  input  logic [13:0] word_addr,
  input  logic [31:0] write_word,
  input  logic [15:0] color,
  input  logic [12:0] x_start,
  input  logic [13:0] span_width,
  input  logic [11:0] top_row,
  input  logic [11:0] dest_row,
  input  logic [12:0] row_count,
  input  pprb_cmd_t   cmd,
  output pprb_sts_t   sts,
  output logic [31:0] read_word,
  output logic        status
);
  logic [2:0]  pix_log2;
  logic [12:0] pitch;
  logic [2:0]  c_kind;
  logic [13:0] c_addr;
  logic [31:0] c_wdata;
  logic [31:0] col;
  logic [11:0] c_top, c_dst;
  logic [12:0] c_rows;
  logic [12:0] w0, w1;
  logic [31:0] lm, rm;
  logic        c_rect, c_down;
  logic [24:0] src_base, dst_base; // row start offsets, row * pitch
  logic [12:0] row_i;
  logic [12:0] wcur;
  logic        bad;
  logic [31:0] src_word;
  logic [31:0] dst_word;
  logic        src_cap, dst_cap;

  // memory port
  logic        we;
  logic [AddrBits-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;

  pprb_ram #(.Width(WordBits), .Depth(StoreWords)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pix_log2 <= 3'd3;
      pitch <= 13'd80;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PIX) pix_log2 <= cfg_data[2:0];
      else pitch <= cfg_data;
    end
  end

  // geometry from input fields
  logic [2:0]  sh;
  logic [4:0]  bpp;
  logic [17:0] first_bit, last_bit;
  logic [31:0] rep;
  logic [15:0] pmask;
  always_comb begin
    sh = (pix_log2 > 3'd4) ? 3'd4 : pix_log2;
    bpp = 5'd1 << sh;
    first_bit = {5'd0, x_start} << sh;
    last_bit = first_bit + ({4'd0, span_width} << sh) - 18'd1;
    pmask = 16'((17'd1 << bpp) - 17'd1);
    rep = '0;
    unique case (sh)
      3'd0: rep = {32{color[0]}};
      3'd1: rep = {16{color[1:0]}};
      3'd2: rep = {8{color[3:0]}};
      3'd3: rep = {4{color[7:0]}};
      default: rep = {2{color & pmask}};
    endcase
  end

  logic [12:0] last_row;
  assign last_row = c_rows - 13'd1;

  // bound products: one multiplier each, combinational; registered at the check step
  logic [25:0] prod_src, prod_dst;
  assign prod_src = ({1'b0, c_top} + {1'b0, last_row}) * pitch;
  assign prod_dst = ({1'b0, c_dst} + {1'b0, last_row}) * pitch;

  // current addresses
  logic [25:0] a_src, a_dst;
  assign a_src = {1'b0, src_base} + {13'd0, wcur};
  assign a_dst = {1'b0, dst_base} + {13'd0, wcur};
  logic is_w0, is_w1;
  logic [31:0] m;
  assign is_w0 = (wcur == w0);
  assign is_w1 = (wcur == w1);
  assign m = (is_w0 ? lm : AllOnes) & (is_w1 ? rm : AllOnes);
  logic word_last, row_last;
  assign word_last = c_down ? is_w0 : is_w1;
  assign row_last = (row_i == last_row);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_kind <= kind;
      c_addr <= word_addr;
      c_wdata <= write_word;
      col <= rep;
      c_top <= top_row;
      c_dst <= dest_row;
      c_rows <= row_count;
      w0 <= first_bit[17:5];
      w1 <= last_bit[17:5];
      lm <= AllOnes >> first_bit[4:0];
      rm <= AllOnes << (5'd31 - last_bit[4:0]);
      c_rect <= (kind == KIND_FILL || kind == KIND_XOR || kind == KIND_COPY)
                && span_width != 14'd0 && row_count != 13'd0;
      c_down <= (kind == KIND_COPY) && (dest_row > top_row);
    end
    if (cmd.check) begin
      row_i <= '0;
      wcur <= c_down ? w1 : w0;
      src_base <= c_down ? prod_src[24:0] : {13'd0, c_top} * pitch;
      dst_base <= c_down ? prod_dst[24:0] : {13'd0, c_dst} * pitch;
      bad <= ({1'b0, prod_src} + {14'd0, w1} >= 27'(StoreWords)) ||
             (c_kind == KIND_COPY &&
              ({1'b0, prod_dst} + {14'd0, w1} >= 27'(StoreWords)));
    end
    if (cmd.step && word_last) begin
      row_i <= row_i + 13'd1;
      wcur <= c_down ? w1 : w0;
      src_base <= c_down ? src_base - {12'd0, pitch} : src_base + {12'd0, pitch};
      dst_base <= c_down ? dst_base - {12'd0, pitch} : dst_base + {12'd0, pitch};
    end else if (cmd.step) begin
      wcur <= c_down ? wcur - 13'd1 : wcur + 13'd1;
    end
    src_cap <= cmd.rd_src;
    dst_cap <= cmd.rd_dst;
    if (src_cap) src_word <= rdata;
    if (dst_cap) dst_word <= rdata;
  end

  // read data of the most recent read, source held separately
  logic [31:0] old_w;
  assign old_w = rdata;

  always_comb begin
    raddr = AddrBits'(a_src);
    if (cmd.rd_dst) raddr = AddrBits'(a_dst);
    if (cmd.do_single) raddr = c_addr;
    we = 1'b0;
    waddr = AddrBits'(a_src);
    wdata = '0;
    if (cmd.do_single && c_kind == KIND_WRITE) begin
      we = 1'b1;
      waddr = c_addr;
      wdata = c_wdata;
    end else if (cmd.wr) begin
      we = 1'b1;
      unique case (c_kind)
        KIND_FILL: wdata = (old_w & ~m) | (col & m);
        KIND_XOR:  wdata = old_w ^ (col & m);
        default: begin
          waddr = AddrBits'(a_dst);
          wdata = (dst_word & ~m) | (src_word & m);
        end
      endcase
    end
  end

  logic single_rd;
  always_ff @(posedge clk) begin
    if (rst) single_rd <= 1'b0;
    else single_rd <= cmd.do_single && c_kind == KIND_READ;
    if (cmd.load) read_word <= '0;
    if (single_rd) read_word <= rdata;
  end

  // word commands: bound is trivially met for 14-bit address at this depth
  assign status = bad && c_rect;
  assign sts.is_word = (c_kind == KIND_WRITE || c_kind == KIND_READ);
  assign sts.is_rect = c_rect;
  assign sts.is_copy = (c_kind == KIND_COPY);
  assign sts.bad = bad;
  assign sts.last = word_last && row_last;

`include "packed_pixel_rect_blitter_macros.svh"
  `PPRB_ASSERT_IMP(a_wr_rect, cmd.wr, c_rect && !bad)
  `PPRB_ASSERT_IMP(a_wr_in_store, cmd.wr && c_kind != KIND_COPY, a_src < 26'(StoreWords))
  `PPRB_ASSERT_IMP(a_cmd_excl, cmd.rd_src, !cmd.wr && !cmd.do_single)
endmodule

@@ hw/rtl/packed_pixel_rect_blitter.sv @@
// channel | handshake            | payload
// in      | in_valid/in_ready    | kind, word_addr, write_word, color, x_start,
//         |                      | span_width, top_row, dest_row, row_count
// out     | out_valid/out_ready  | read_word, status
// cfg     | cfg_valid/cfg_ready  | cfg_index, cfg_data
// Word commands pass setup and a single RAM access, then the output handshake.
// Fill and xor read, merge and write back each covered word; copy also reads
// the destination word (registered RAM read, then merge and write back).
// Setup passes the GEOM and CHECK states; result is held until out_ready.
// Reset returns control to idle and config registers to defaults; store contents stay undefined.
module packed_pixel_rect_blitter
  import pprb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [13:0] word_addr,
  input  logic [31:0] write_word,
  input  logic [15:0] color,
  input  logic [12:0] x_start,
  input  logic [13:0] span_width,
  input  logic [11:0] top_row,
  input  logic [11:0] dest_row,
  input  logic [12:0] row_count,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] read_word,
  output logic        status,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data
);
  pprb_cmd_t cmd;
  pprb_sts_t sts;
  assign cfg_ready = 1'b1;

  pprb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .sts(sts), .cmd(cmd)
  );

  pprb_dp u_dp (
    .clk(clk), .rst(rst), .cfg_valid(cfg_valid), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .kind(kind), .word_addr(word_addr),
    .write_word(write_word), .color(color), .x_start(x_start),
    .span_width(span_width), .top_row(top_row), .dest_row(dest_row),
    .row_count(row_count), .cmd(cmd), .sts(sts), .read_word(read_word),
    .status(status)
  );
endmodule
